// ===== design/btds_pkg.sv =====
// shared types and codes for the byte translate / delete / squeeze filter
`timescale 1ns / 1ps
package btds_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_LOAD_SET = 2'd0;
    localparam logic [1:0] MODE_LOAD_REP = 2'd1;
    localparam logic [1:0] MODE_DATA     = 2'd2;

    // operation register codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_DELETE    = 2'd1;
    localparam logic [1:0] OP_SQUEEZE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OPERATION  = 2'd0;
    localparam logic [1:0] CFG_COMPLEMENT = 2'd1;
    localparam logic [1:0] CFG_SET_COUNT  = 2'd2;
    localparam logic [1:0] CFG_REP_COUNT  = 2'd3;

    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE,
        S_FETCH,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic scan_rd;
        logic lookup;
        logic take;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic need_lookup;
        logic keep;
        logic out_free;
    } t_stat;

endpackage

// ===== design/btds_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module btds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/btds_ctrl.sv =====
// sequencer: table scan, replacement lookup and result hand-off
`timescale 1ns / 1ps
module btds_ctrl #(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [1:0]      i_mode,
    input  btds_pkg::t_stat i_stat,
    input  logic [CW-1:0]   i_scan_n,
    output btds_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_rd_addr
);
    import btds_pkg::*;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_addr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                n_cnt          = '0;
                if (i_s_tvalid && i_mode == MODE_DATA) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.need_scan && i_scan_n != '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RESOLVE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (CW'(r_cnt) == i_scan_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands here
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (i_stat.need_lookup) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = S_FETCH;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FETCH: begin
                o_cmd.take = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.keep) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_rd |-> (CW'(o_rd_addr) < i_scan_n))
        else $error("scan address beyond active entries");

    a_fetch_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ($past(r_state) == S_RESOLVE && $past(o_cmd.lookup)))
        else $error("fetch without lookup");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (i_stat.out_free && i_stat.keep))
        else $error("push into a full output register");
`endif

endmodule

// ===== design/btds_dp.sv =====
// datapath: config registers, set tables, match compare and output register
`timescale 1ns / 1ps
module btds_dp #(
    parameter int SET_MAX = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [6:0]      i_cfg_data,
    input  logic            i_s_tvalid,
    input  logic [15:0]     i_s_tdata,
    input  logic [1:0]      i_s_tuser,
    input  btds_pkg::t_cmd  i_cmd,
    input  logic [AW-1:0]   i_rd_addr,
    output btds_pkg::t_stat o_stat,
    output logic [CW-1:0]   o_scan_n,
    output logic            o_m_tvalid,
    output logic [7:0]      o_m_tdata,
    input  logic            i_m_tready
);
    import btds_pkg::*;

    logic [1:0]        r_op;
    logic              r_comp;
    logic [6:0]        r_set_count;
    logic [6:0]        r_rep_count;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_prev;
    logic [BYTE_W-1:0] r_last;
    logic              r_found;
    logic [AW-1:0]     r_hit_idx;
    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_data;

    logic [1:0]        w_mode;
    logic [5:0]        w_idx;
    logic [BYTE_W-1:0] w_val;
    logic              w_acc;
    logic              w_idx_ok;
    logic              w_we_set;
    logic              w_we_rep;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_lookup_addr;
    logic [BYTE_W-1:0] w_set_rdata;
    logic [BYTE_W-1:0] w_rep_rdata;
    logic [BYTE_W-1:0] w_cmp_data;
    logic              w_hit;
    logic [CW-1:0]     w_ns;
    logic [CW-1:0]     w_nr_sat;
    logic [CW-1:0]     w_nr;
    logic              w_eq;
    logic              w_hit_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_TRANSLATE;
            r_comp      <= 1'b0;
            r_set_count <= 7'd0;
            r_rep_count <= 7'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OPERATION:  r_op        <= i_cfg_data[1:0];
                CFG_COMPLEMENT: r_comp      <= i_cfg_data[0];
                CFG_SET_COUNT:  r_set_count <= i_cfg_data;
                CFG_REP_COUNT:  r_rep_count <= i_cfg_data;
            endcase
        end
    end

    // active entry counts, saturated; empty replacement set counts as one
    assign w_ns     = (32'(r_set_count) > SET_MAX) ? CW'(SET_MAX) : CW'(r_set_count);
    assign w_nr_sat = (32'(r_rep_count) > SET_MAX) ? CW'(SET_MAX) : CW'(r_rep_count);
    assign w_nr     = (w_nr_sat == '0) ? CW'(1) : w_nr_sat;

    assign w_mode   = i_s_tuser;
    assign w_idx    = i_s_tdata[5:0];
    assign w_val    = i_s_tdata[13:6];
    assign w_acc    = i_s_tvalid && i_cmd.in_ready;
    assign w_idx_ok = 32'(w_idx) < SET_MAX;
    assign w_we_set = w_acc && w_mode == MODE_LOAD_SET && w_idx_ok;
    assign w_we_rep = w_acc && w_mode == MODE_LOAD_REP && w_idx_ok;
    assign w_waddr  = AW'(w_idx);
    assign w_raddr  = i_cmd.lookup ? w_lookup_addr : i_rd_addr;

    btds_ram #(.WIDTH(BYTE_W), .DEPTH(SET_MAX)) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_set),
        .i_waddr (w_waddr),
        .i_wdata (w_val),
        .i_raddr (w_raddr),
        .o_rdata (w_set_rdata)
    );

    btds_ram #(.WIDTH(BYTE_W), .DEPTH(SET_MAX)) u_rep_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_rep),
        .i_waddr (w_waddr),
        .i_wdata (w_val),
        .i_raddr (w_raddr),
        .o_rdata (w_rep_rdata)
    );

    // squeeze scans the replacement table, the others the match table
    assign w_cmp_data = (r_op == OP_SQUEEZE) ? w_rep_rdata : w_set_rdata;
    assign w_hit      = r_cmp_vld && (w_cmp_data == r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_found   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (w_acc && w_mode == MODE_DATA) begin
                r_last  <= w_val;
                r_found <= 1'b0;
            end else if (w_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= i_rd_addr;
        if (w_acc && w_mode == MODE_DATA) begin
            r_byte <= w_val;
            r_prev <= r_last;
        end else if (i_cmd.take) begin
            r_byte <= w_rep_rdata;
        end
        if (w_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.push) begin
            r_out_data <= r_byte;
        end
    end

    assign w_eq          = (r_byte == r_prev);
    assign w_hit_ok      = CW'(r_hit_idx) < w_nr;
    assign w_lookup_addr = (r_comp || !w_hit_ok) ? AW'(w_nr - 1'b1) : r_hit_idx;

    assign o_scan_n = (r_op == OP_SQUEEZE) ? w_nr : w_ns;

    always_comb begin
        o_stat          = '0;
        o_stat.out_free = !r_out_vld || i_m_tready;
        o_stat.keep     = 1'b1;
        case (r_op)
            OP_TRANSLATE: begin
                o_stat.need_scan   = 1'b1;
                o_stat.need_lookup = r_comp ? !r_found : r_found;
            end
            OP_DELETE: begin
                o_stat.need_scan = 1'b1;
                o_stat.keep      = !(r_found ^ r_comp);
            end
            OP_SQUEEZE: begin
                o_stat.need_scan = w_eq;
                o_stat.keep      = !(w_eq && (r_found ^ r_comp));
            end
            default: begin
                o_stat.keep = 1'b1;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_lookup_translate_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> (r_op == OP_TRANSLATE))
        else $error("replacement lookup outside translate");

    a_found_from_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(r_cmp_vld))
        else $error("match flag set without a compare");

    a_take_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> $past(i_cmd.lookup))
        else $error("replacement taken without a read");
`endif

endmodule

// ===== design/byte_translate_delete_squeeze_top.sv =====
// top level of the tr-style byte translate / delete / squeeze filter
// load items write their table entry on accept; a data item scans n entries (set_count
// in translate and delete, rep_count but at least one for a repeated byte in squeeze,
// none otherwise, capped at SET_MAX), resolves, may read a replacement in translate,
// and is dropped or waits for a free output register; the next item goes in after that
// reset (synchronous, active low) clears config, state and flags; tables stay unwritten
`timescale 1ns / 1ps
module byte_translate_delete_squeeze_top #(
    parameter int SET_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [5:0] entry_index, [13:6] byte_value, [15:14] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [7:0] out_byte
);
    import btds_pkg::*;

    // table address and entry count widths
    localparam int AW = (SET_MAX > 1) ? $clog2(SET_MAX) : 1;
    localparam int CW = $clog2(SET_MAX + 1);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [AW-1:0] w_rd_addr;
    logic [CW-1:0] w_scan_n;

    // input side is open only while the sequencer waits for an item
    assign o_s_axis_tready = w_cmd.in_ready;

    // sequencer: walks the active table entries one per cycle, then
    // optionally reads the replacement entry and hands off the result
    btds_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_mode     (i_s_axis_tuser),
        .i_stat     (w_stat),
        .i_scan_n   (w_scan_n),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    // datapath: config registers, both set tables, compare against the
    // held byte with last-match capture, and the output register that lets
    // a new item in while the previous result still waits
    btds_dp #(.SET_MAX(SET_MAX), .AW(AW), .CW(CW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .o_stat      (w_stat),
        .o_scan_n    (w_scan_n),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .i_m_tready  (i_m_axis_tready)
    );

endmodule
